FILE: rtl/ipew_pkg.sv
// Shared types and constants for the page entry writer.
// No dependencies; imported by every module of the block.
package ipew_pkg;

    // Fixed field widths of the request and result channels
    localparam int KIND_W   = 1;
    localparam int PADDR_W  = 48;
    localparam int LEN_W    = 21;
    localparam int VADDR_W  = 32;
    localparam int INDEX_W  = 18;
    localparam int ENTRY_W  = 64;
    localparam int SHIFT_W  = 3;

    // Widest in-page offset (largest supported page) and page counter
    localparam int OFF_W    = 16;
    localparam int CNT_W    = 7;
    // offset + length + page mask never exceeds this
    localparam int SUM_W    = 23;

    // Entry word layout
    localparam int START_POS      = 52;
    localparam int END_POS        = 40;
    localparam int OFS_ALIGN_MASK = 7;
    localparam logic [ENTRY_W-1:0] ENTRY_VALID = 64'h1;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_MAP   = 1'b0;
    localparam logic [KIND_W-1:0] KIND_UNMAP = 1'b1;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Classified segment handed from front to back
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               too_long;
        logic [CNT_W-1:0]   pages;
        logic [OFF_W-1:0]   off;
        logic [PADDR_W-1:0] ppage;
        logic [VADDR_W-1:0] vbase;
        logic [VADDR_W-1:0] dev;
    } seg_desc_t;

endpackage

FILE: rtl/iommu_page_entry_writer_top.sv
// Top level of the page entry writer: front end, descriptor queue, back end.
// Depends on ipew_pkg, ipew_front, ipew_queue, ipew_back.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------------
//  s_      | s_valid / s_ready  | kind, phys_addr, seg_len, virt_base
//  m_      | m_valid / m_ready  | entry_index, entry_value, device_addr, last, too_long
//  cfg_    | cfg_wr_en          | cfg_wr_data (phys_shift)
//
// A request is taken while the two-entry queue has room. The back end loads a
// segment from the queue and then emits one entry per cycle while m_ready does
// not stall it, so a segment of N pages yields N entries (one for a too-long
// request); zero-length requests are dropped at the front. Reset (aresetn,
// synchronous) empties the queue and result register and clears phys_shift.
// m_ready low holds the result register and stalls the page walk; the front
// keeps taking requests until the queue fills.
module iommu_page_entry_writer_top #(
    parameter int MAX_PAGES  = 64,
    parameter int PAGE_BYTES = 16384
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ipew_pkg::SHIFT_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ipew_pkg::KIND_W-1:0]   s_kind,
    input  logic [ipew_pkg::PADDR_W-1:0]  s_phys_addr,
    input  logic [ipew_pkg::LEN_W-1:0]    s_seg_len,
    input  logic [ipew_pkg::VADDR_W-1:0]  s_virt_base,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ipew_pkg::INDEX_W-1:0]  m_entry_index,
    output logic [ipew_pkg::ENTRY_W-1:0]  m_entry_value,
    output logic [ipew_pkg::VADDR_W-1:0]  m_device_addr,
    output logic                          m_last,
    output logic                          m_too_long
);
    import ipew_pkg::*;

    logic [SHIFT_W-1:0] phys_shift_reg;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    seg_desc_t          q_wdata;
    seg_desc_t          q_rdata;

    // Physical shift register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phys_shift_reg <= '0;
        end else if (cfg_wr_en) begin
            phys_shift_reg <= cfg_wr_data;
        end
    end

    ipew_front #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_phys_addr (s_phys_addr),
        .s_seg_len   (s_seg_len),
        .s_virt_base (s_virt_base),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    ipew_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    ipew_back #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .phys_shift    (phys_shift_reg),
        .q_empty       (q_empty),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_index (m_entry_index),
        .m_entry_value (m_entry_value),
        .m_device_addr (m_device_addr),
        .m_last        (m_last),
        .m_too_long    (m_too_long)
    );

endmodule

FILE: rtl/ipew_front.sv
// Request front end: splits the address, rounds the length, classifies the segment.
// Depends on ipew_pkg; feeds ipew_queue.
module ipew_front #(
    parameter int MAX_PAGES  = 64,
    parameter int PAGE_BYTES = 16384
) (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ipew_pkg::KIND_W-1:0]   s_kind,
    input  logic [ipew_pkg::PADDR_W-1:0]  s_phys_addr,
    input  logic [ipew_pkg::LEN_W-1:0]    s_seg_len,
    input  logic [ipew_pkg::VADDR_W-1:0]  s_virt_base,
    input  logic                          q_full,
    output logic                          q_push,
    output ipew_pkg::seg_desc_t           q_wdata
);
    import ipew_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PMASK      = PAGE_BYTES - 1;

    logic [OFF_W-1:0] off;
    logic [SUM_W-1:0] round_sum;
    logic [SUM_W-1:0] pages_wide;
    logic             too_long;
    logic             zero_len;

    // Offset inside the first page; unmap always starts on a page
    assign off = (s_kind == KIND_UNMAP) ? '0 : (s_phys_addr[OFF_W-1:0] & OFF_W'(PMASK));

    // Round offset plus length up to whole pages
    assign round_sum  = SUM_W'(s_seg_len) + SUM_W'(off) + SUM_W'(PMASK);
    assign pages_wide = round_sum >> PAGE_SHIFT;
    assign too_long   = pages_wide > SUM_W'(MAX_PAGES);
    assign zero_len   = (s_seg_len == '0);

    // Accept whenever the queue has room; zero-length requests are dropped
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && !zero_len;

    // Descriptor for the back end
    always_comb begin
        q_wdata          = '0;
        q_wdata.kind     = s_kind;
        q_wdata.too_long = too_long;
        q_wdata.pages    = pages_wide[CNT_W-1:0];
        q_wdata.off      = off;
        q_wdata.ppage    = s_phys_addr & ~PADDR_W'(PMASK);
        q_wdata.vbase    = s_virt_base & ~VADDR_W'(PMASK);
        q_wdata.dev      = (s_virt_base & ~VADDR_W'(PMASK)) + VADDR_W'(off);
    end

endmodule

FILE: rtl/ipew_queue.sv
// Two-entry descriptor queue between the front and back ends.
// Depends on ipew_pkg.
module ipew_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ipew_pkg::seg_desc_t  wdata,
    input  logic                 pop,
    output ipew_pkg::seg_desc_t  rdata,
    output logic                 full,
    output logic                 empty
);
    import ipew_pkg::*;

    seg_desc_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/ipew_back.sv
// Back end: walks the pages of one segment and emits one entry per cycle while m_ready allows.
// Depends on ipew_pkg; drains ipew_queue, drives the result register.
module ipew_back #(
    parameter int PAGE_BYTES = 16384
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ipew_pkg::SHIFT_W-1:0]  phys_shift,
    input  logic                          q_empty,
    input  ipew_pkg::seg_desc_t           q_rdata,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ipew_pkg::INDEX_W-1:0]  m_entry_index,
    output logic [ipew_pkg::ENTRY_W-1:0]  m_entry_value,
    output logic [ipew_pkg::VADDR_W-1:0]  m_device_addr,
    output logic                          m_last,
    output logic                          m_too_long
);
    import ipew_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [ENTRY_W-1:0] END_FIELD =
        (ENTRY_W'(PAGE_BYTES - 1) >> 2) << END_POS;

    // Segment walk state
    logic               busy_reg, busy_next;
    seg_desc_t          desc_reg, desc_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [VADDR_W-1:0] va_reg, va_next;
    logic [PADDR_W-1:0] pa_reg, pa_next;

    // Result register
    logic               m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [ENTRY_W-1:0] value_reg, value_next;
    logic [VADDR_W-1:0] dev_reg, dev_next;
    logic               last_reg, last_next;
    logic               too_long_reg, too_long_next;

    logic               emit;
    logic               is_last;
    logic [VADDR_W-1:0] idx_wide;
    logic [OFF_W-1:0]   start_ofs;
    logic [ENTRY_W-1:0] map_value;

    assign q_pop = !busy_reg && !q_empty;
    assign emit  = busy_reg && (!m_valid_reg || m_ready);

    // Entry for the current page
    assign is_last   = (CNT_W'(k_reg + 1'b1) == desc_reg.pages);
    assign idx_wide  = va_reg >> PAGE_SHIFT;
    assign start_ofs = (k_reg == '0) ? (desc_reg.off & ~OFF_W'(OFS_ALIGN_MASK)) : '0;
    assign map_value = ((ENTRY_W'(pa_reg)) >> phys_shift) | ENTRY_VALID
                     | ((ENTRY_W'(start_ofs) >> 2) << START_POS) | END_FIELD;

    always_comb begin
        busy_next     = busy_reg;
        desc_next     = desc_reg;
        k_next        = k_reg;
        va_next       = va_reg;
        pa_next       = pa_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        index_next    = index_reg;
        value_next    = value_reg;
        dev_next      = dev_reg;
        last_next     = last_reg;
        too_long_next = too_long_reg;

        // Load the next segment
        if (q_pop) begin
            busy_next = 1'b1;
            desc_next = q_rdata;
            k_next    = '0;
            va_next   = q_rdata.vbase;
            pa_next   = q_rdata.ppage;
        end

        // Emit one result and step to the next page
        if (emit) begin
            m_valid_next = 1'b1;
            if (desc_reg.too_long) begin
                index_next    = '0;
                value_next    = '0;
                dev_next      = '0;
                last_next     = 1'b1;
                too_long_next = 1'b1;
                busy_next     = 1'b0;
            end else begin
                index_next    = idx_wide[INDEX_W-1:0];
                value_next    = (desc_reg.kind == KIND_MAP) ? map_value : '0;
                dev_next      = desc_reg.dev;
                last_next     = is_last;
                too_long_next = 1'b0;
                busy_next     = !is_last;
                k_next        = k_reg + 1'b1;
                va_next       = va_reg + VADDR_W'(PAGE_BYTES);
                pa_next       = pa_reg + PADDR_W'(PAGE_BYTES);
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        desc_reg     <= desc_next;
        k_reg        <= k_next;
        va_reg       <= va_next;
        pa_reg       <= pa_next;
        index_reg    <= index_next;
        value_reg    <= value_next;
        dev_reg      <= dev_next;
        last_reg     <= last_next;
        too_long_reg <= too_long_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_entry_index = index_reg;
    assign m_entry_value = value_reg;
    assign m_device_addr = dev_reg;
    assign m_last        = last_reg;
    assign m_too_long    = too_long_reg;

endmodule
